/* hdl/xvs_pkg.sv */
// shared types, constants and helper functions of the xsph velocity smoothing block
// no dependencies; every other file refers to this package by scoped names
package xvs_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COEF_BITS   = 16;
    localparam int VEL_W       = 32;
    localparam int ACC_W       = 64;
    localparam int FDIV_STEPS  = 64;
    localparam int NDIV_STEPS  = ACC_W + FRAC_BITS;
    localparam int QLIM_LOG    = 40;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int ADDR_W      = 5;

    localparam logic [COEF_BITS-1:0] BOUNDARY_COEF = 16'd393;
    localparam logic [31:0]          DIV5_RECIP    = 32'd52429;

    // register indexes
    localparam logic [2:0] REG_DIMS   = 3'd0;
    localparam logic [2:0] REG_WATER  = 3'd1;
    localparam logic [2:0] REG_SOIL   = 3'd2;
    localparam logic [2:0] REG_AIR    = 3'd3;
    localparam logic [2:0] REG_THRESH = 3'd4;

    // particle phases
    localparam logic [2:0] T_BOUNDARY = 3'd0;
    localparam logic [2:0] T_WATER    = 3'd1;
    localparam logic [2:0] T_SOIL     = 3'd2;
    localparam logic [2:0] T_AIR      = 3'd3;
    localparam logic [2:0] T_STRUCT   = 3'd4;
    localparam logic [2:0] T_EXCL     = 3'd7;

    typedef struct packed {
        logic [1:0]           dims;
        logic [COEF_BITS-1:0] coef_water;
        logic [COEF_BITS-1:0] coef_soil;
        logic [COEF_BITS-1:0] coef_air;
        logic [15:0]          thresh;
    } t_cfg;

    typedef struct packed {
        logic [2:0]              ct;
        logic signed [VEL_W-1:0] cvx;
        logic signed [VEL_W-1:0] cvy;
        logic signed [VEL_W-1:0] cvz;
        logic signed [VEL_W-1:0] nvx;
        logic signed [VEL_W-1:0] nvy;
        logic signed [VEL_W-1:0] nvz;
        logic signed [VEL_W-1:0] t;
        logic [COEF_BITS-1:0]    coef;
        logic                    contrib;
        logic                    last;
    } t_job;

    function automatic logic signed [ACC_W-1:0] sat_add64(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

/* hdl/xvs_if.sv */
// stream channels of the xsph velocity smoothing block: neighbor pairs in, velocities out
// depends on xvs_pkg for widths
interface xvs_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [2:0]                            center_type;
    logic signed [xvs_pkg::VEL_W-1:0]      center_vx;
    logic signed [xvs_pkg::VEL_W-1:0]      center_vy;
    logic signed [xvs_pkg::VEL_W-1:0]      center_vz;
    logic [2:0]                            nbr_type;
    logic signed [xvs_pkg::VEL_W-1:0]      nbr_vx;
    logic signed [xvs_pkg::VEL_W-1:0]      nbr_vy;
    logic signed [xvs_pkg::VEL_W-1:0]      nbr_vz;
    logic [31:0]                           nbr_mass;
    logic [31:0]                           nbr_density;
    logic signed [31:0]                    kernel_weight;
    logic                                  last;

    modport source (output valid, center_type, center_vx, center_vy, center_vz, nbr_type,
                    nbr_vx, nbr_vy, nbr_vz, nbr_mass, nbr_density, kernel_weight, last,
                    input ready);
    modport sink (input valid, center_type, center_vx, center_vy, center_vz, nbr_type,
                  nbr_vx, nbr_vy, nbr_vz, nbr_mass, nbr_density, kernel_weight, last,
                  output ready);
endinterface

interface xvs_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [xvs_pkg::VEL_W-1:0]      out_vx;
    logic signed [xvs_pkg::VEL_W-1:0]      out_vy;
    logic signed [xvs_pkg::VEL_W-1:0]      out_vz;
    logic                                  updated;

    modport source (output valid, out_vx, out_vy, out_vz, updated, input ready);
    modport sink (input valid, out_vx, out_vy, out_vz, updated, output ready);
endinterface

/* hdl/xvs_front.sv */
// front part: accepts a neighbor pair, classifies it, computes t = mass*w/rho
// depends on xvs_pkg and xvs_in_if; feeds xvs_queue
module xvs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    xvs_in_if.sink            i_in,
    input  xvs_pkg::t_cfg     i_cfg,
    output xvs_pkg::t_job     o_job,
    output logic              o_push,
    input  logic              i_full
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_DIV  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]  r_state;
    xvs_pkg::t_job r_job;
    logic [31:0] r_mass, r_rho, r_wmag;
    logic        r_wneg;
    logic [63:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [5:0]  r_cnt;
    logic [32:0] rem2;
    logic        ge;

    logic                           same, bnd, contrib;
    logic [xvs_pkg::COEF_BITS-1:0]  coef, soil_div5;
    logic                           accept;

    assign i_in.ready = (r_state == F_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign soil_div5  = 16'((32'(i_cfg.coef_soil) * xvs_pkg::DIV5_RECIP) >> 18);

    always_comb begin
        same = (i_in.center_type == i_in.nbr_type) && (i_in.center_type != xvs_pkg::T_BOUNDARY)
               && (i_in.center_type != xvs_pkg::T_EXCL);
        bnd  = (i_in.center_type >= xvs_pkg::T_WATER) && (i_in.center_type <= xvs_pkg::T_STRUCT)
               && (i_in.nbr_type == xvs_pkg::T_BOUNDARY);
        contrib = same || bnd;
        coef = '0;
        if (same) begin
            case (i_in.center_type) inside
                xvs_pkg::T_WATER:                   coef = i_cfg.coef_water;
                xvs_pkg::T_SOIL, xvs_pkg::T_STRUCT: coef = i_cfg.coef_soil;
                xvs_pkg::T_AIR:                     coef = i_cfg.coef_air;
                default:                            coef = '0;
            endcase
        end else if (bnd) begin
            coef = (i_in.center_type == xvs_pkg::T_WATER || i_in.center_type == xvs_pkg::T_AIR)
                   ? xvs_pkg::BOUNDARY_COEF : soil_div5;
        end
    end

    // restoring divide step, one quotient bit per cycle
    always_comb begin
        rem2  = {r_rem, r_quo[63]};
        ge    = (rem2 >= {1'b0, r_rho});
        n_rem = ge ? 32'(rem2 - {1'b0, r_rho}) : rem2[31:0];
        n_quo = {r_quo[62:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_state <= contrib ? F_MUL : F_PUSH;
                    end
                end
                F_MUL: begin
                    r_state <= (r_rho == '0) ? F_PUSH : F_DIV;
                end
                F_DIV: begin
                    if (r_cnt == 6'(xvs_pkg::FDIV_STEPS - 1)) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    r_job.ct      <= i_in.center_type;
                    r_job.cvx     <= i_in.center_vx;
                    r_job.cvy     <= i_in.center_vy;
                    r_job.cvz     <= i_in.center_vz;
                    r_job.nvx     <= i_in.nbr_vx;
                    r_job.nvy     <= i_in.nbr_vy;
                    r_job.nvz     <= i_in.nbr_vz;
                    r_job.t       <= '0;
                    r_job.coef    <= coef;
                    r_job.contrib <= contrib;
                    r_job.last    <= i_in.last;
                    r_mass        <= i_in.nbr_mass;
                    r_rho         <= i_in.nbr_density;
                    r_wneg        <= i_in.kernel_weight[31];
                    r_wmag        <= i_in.kernel_weight[31] ? 32'(-i_in.kernel_weight)
                                                            : 32'(i_in.kernel_weight);
                end
            end
            F_MUL: begin
                r_quo <= 64'(r_mass) * 64'(r_wmag);
                r_rem <= '0;
                r_cnt <= '0;
            end
            F_DIV: begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(xvs_pkg::FDIV_STEPS - 1)) begin
                    if (r_wneg) begin
                        r_job.t <= (n_quo > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-n_quo);
                    end else begin
                        r_job.t <= (n_quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(n_quo);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_job  = r_job;
    assign o_push = (r_state == F_PUSH) && !i_full;

endmodule

/* hdl/xvs_queue.sv */
// short job queue between the front and back parts
// depends on xvs_pkg for the job type and depth
module xvs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  xvs_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output xvs_pkg::t_job o_data,
    output logic          o_empty
);
    xvs_pkg::t_job                r_mem [xvs_pkg::QDEPTH];
    logic [xvs_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [xvs_pkg::QPTR_W:0]     r_count;

    assign o_full  = (r_count == (xvs_pkg::QPTR_W+1)'(xvs_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (xvs_pkg::QPTR_W+1)'(xvs_pkg::QDEPTH))
        else $error("queue count beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_full |-> !i_push)
        else $error("push into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

/* hdl/xvs_back.sv */
// back part: accumulates weighted velocity differences, normalizes and emits the result
// depends on xvs_pkg and xvs_out_if; drains xvs_queue
module xvs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xvs_pkg::t_cfg     i_cfg,
    input  xvs_pkg::t_job     i_job,
    input  logic              i_empty,
    output logic              o_pop,
    xvs_out_if.source         o_out
);
    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_WT   = 3'd1;
    localparam logic [2:0] B_MUL  = 3'd2;
    localparam logic [2:0] B_ACC  = 3'd3;
    localparam logic [2:0] B_FIN  = 3'd4;
    localparam logic [2:0] B_DIV  = 3'd5;
    localparam logic [2:0] B_EMIT = 3'd6;

    localparam int DQ_W  = xvs_pkg::NDIV_STEPS;
    localparam int CNT_W = $clog2(DQ_W);
    localparam logic signed [63:0] QLIM = 64'sd1 <<< xvs_pkg::QLIM_LOG;

    logic [2:0]                     r_state;
    xvs_pkg::t_job                  r_e;
    logic [1:0]                     r_k;
    logic signed [31:0]             r_wt;
    logic signed [64:0]             r_prod;
    logic signed [63:0]             r_sum [3];
    logic signed [63:0]             r_sw;
    logic signed [31:0]             r_res [3];
    logic [63:0]                    r_rem, n_rem, r_nb;
    logic [DQ_W-1:0]                r_dq, n_dq;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_neg;
    logic                           r_ovalid;
    logic signed [31:0]             r_ovx, r_ovy, r_ovz;
    logic                           r_oupd;

    logic signed [31:0]  cv [3];
    logic signed [31:0]  nv [3];
    logic                three, pass, norm, last_k, load;
    logic [1:0]          ncomp_m1;
    logic [63:0]         wm, sm;
    logic signed [48:0]  ct_prod;
    logic signed [32:0]  diff;
    logic [64:0]         rem2;
    logic                ge;
    logic [DQ_W-1:0]     qlim_q;
    logic signed [63:0]  nres;

    function automatic logic signed [31:0] finish(
        input logic signed [31:0] v,
        input logic signed [63:0] corr
    );
        logic signed [63:0] c;
        logic signed [63:0] r;
        c = (corr < -QLIM) ? -QLIM : ((corr > QLIM) ? QLIM : corr);
        r = 64'(v) + c;
        if (r > 64'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end
        if (r < -64'sh8000_0000) begin
            return 32'sh8000_0000;
        end
        return r[31:0];
    endfunction

    assign cv[0] = r_e.cvx;
    assign cv[1] = r_e.cvy;
    assign cv[2] = r_e.cvz;
    assign nv[0] = r_e.nvx;
    assign nv[1] = r_e.nvy;
    assign nv[2] = r_e.nvz;

    assign three    = (i_cfg.dims != 2'd2);
    assign ncomp_m1 = three ? 2'd2 : 2'd1;
    assign pass     = (r_e.ct == xvs_pkg::T_BOUNDARY) || (r_e.ct == xvs_pkg::T_EXCL);
    assign wm       = r_sw[63] ? 64'(-r_sw) : 64'(r_sw);
    assign sm       = r_sum[r_k][63] ? 64'(-r_sum[r_k]) : 64'(r_sum[r_k]);
    assign norm     = (r_e.ct == xvs_pkg::T_SOIL || r_e.ct == xvs_pkg::T_STRUCT)
                      && (wm != '0) && (wm >= 64'(i_cfg.thresh));
    assign last_k   = (r_k == 2'd2);
    assign ct_prod  = $signed({1'b0, r_e.coef}) * 49'(r_e.t);
    assign diff     = 33'(nv[r_k]) - 33'(cv[r_k]);
    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign load     = (r_state == B_EMIT) && (!r_ovalid || o_out.ready);

    // restoring divide step for the normalized quotient
    assign rem2   = {r_rem, r_dq[DQ_W-1]};
    assign ge     = (rem2 >= {1'b0, r_nb});
    assign n_rem  = ge ? 64'(rem2 - {1'b0, r_nb}) : rem2[63:0];
    assign n_dq   = {r_dq[DQ_W-2:0], ge};
    assign qlim_q = DQ_W'(1) << xvs_pkg::QLIM_LOG;
    assign nres   = (n_dq > qlim_q) ? QLIM : 64'(n_dq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
            r_sum[0] <= '0;
            r_sum[1] <= '0;
            r_sum[2] <= '0;
            r_sw     <= '0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        if (i_job.contrib) begin
                            r_state <= B_WT;
                        end else if (i_job.last) begin
                            r_state <= B_FIN;
                        end
                    end
                end
                B_WT: begin
                    r_sw    <= xvs_pkg::sat_add64(r_sw, 64'(r_e.t));
                    r_state <= B_MUL;
                end
                B_MUL: begin
                    r_state <= B_ACC;
                end
                B_ACC: begin
                    r_sum[r_k] <= xvs_pkg::sat_add64(r_sum[r_k],
                                                     64'(r_prod >>> xvs_pkg::FRAC_BITS));
                    if (r_k == ncomp_m1) begin
                        r_state <= r_e.last ? B_FIN : B_IDLE;
                    end else begin
                        r_state <= B_MUL;
                    end
                end
                B_FIN: begin
                    if (!pass && !(r_k == 2'd2 && !three) && norm) begin
                        r_state <= B_DIV;
                    end else if (last_k) begin
                        r_state <= B_EMIT;
                    end
                end
                B_DIV: begin
                    if (r_cnt == CNT_W'(DQ_W - 1)) begin
                        r_state <= last_k ? B_EMIT : B_FIN;
                    end
                end
                B_EMIT: begin
                    if (load) begin
                        r_sum[0] <= '0;
                        r_sum[1] <= '0;
                        r_sum[2] <= '0;
                        r_sw     <= '0;
                        r_state  <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_k <= '0;
                if (!i_empty) begin
                    r_e <= i_job;
                end
            end
            B_WT: begin
                r_wt <= 32'(ct_prod >>> xvs_pkg::COEF_BITS);
            end
            B_MUL: begin
                r_prod <= 65'(r_wt) * 65'(diff);
            end
            B_ACC: begin
                r_k <= (r_k == ncomp_m1) ? 2'd0 : r_k + 2'd1;
            end
            B_FIN: begin
                if (pass || (r_k == 2'd2 && !three)) begin
                    r_res[r_k] <= cv[r_k];
                    r_k        <= r_k + 2'd1;
                end else if (norm) begin
                    r_rem <= '0;
                    r_nb  <= wm;
                    r_dq  <= {sm, {xvs_pkg::FRAC_BITS{1'b0}}};
                    r_cnt <= '0;
                    r_neg <= r_sum[r_k][63] != r_sw[63];
                end else begin
                    r_res[r_k] <= finish(cv[r_k], r_sum[r_k]);
                    r_k        <= r_k + 2'd1;
                end
            end
            B_DIV: begin
                r_rem <= n_rem;
                r_dq  <= n_dq;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DQ_W - 1)) begin
                    r_res[r_k] <= finish(cv[r_k], r_neg ? -nres : nres);
                    r_k        <= r_k + 2'd1;
                end
            end
            B_EMIT: begin
                if (load) begin
                    r_ovx  <= r_res[0];
                    r_ovy  <= r_res[1];
                    r_ovz  <= r_res[2];
                    r_oupd <= !pass;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.out_vx  = r_ovx;
    assign o_out.out_vy  = r_ovy;
    assign o_out.out_vz  = r_ovz;
    assign o_out.updated = r_oupd;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) load |=> o_out.valid)
        else $error("result register not loaded");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) load |=> (r_sw == '0))
        else $error("weight sum not cleared after a result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) (r_state != B_IDLE) |-> !o_pop)
        else $error("queue popped while busy");

endmodule

/* hdl/xsph_velocity_smoothing.sv */
// top level of the xsph velocity smoothing block: register port, front, queue, back
// depends on xvs_pkg, xvs_if, xvs_front, xvs_queue and xvs_back
//
// usage
// - i_in carries one neighbor pair per transfer (valid/ready); last marks the
//   final pair of a particle, and the center fields of that pair decide the result
// - o_out carries one corrected velocity per particle, after its last pair
// - the apb port writes dimensions, coef_water, coef_soil, coef_air and
//   weight_threshold at byte addresses 0, 4, 8, 12, 16; pready is always high
//   and reads return the register value; write only while the block is idle
// - the front takes one pair at a time: a contributing pair passes a multiply
//   state and the bit-serial mass*w/rho divider, which is skipped when rho is
//   zero; a pair that contributes nothing goes straight to the push state
// - the back weights a contributing pair, then multiplies and accumulates each
//   component, the components sharing one multiplier; a last pair adds a finish
//   state per component, and the 80-step divider for normalized soil/structure
// - a two-entry queue decouples front from back, and the output register lets
//   the back finish the next particle's pairs while a result waits
// - reset (synchronous, active low) restores the register defaults, clears the
//   sums and empties the queue
// - when the receiver stalls, the result holds; the back stalls at the next last
//   pair, then the queue fills and i_in.ready drops
module xsph_velocity_smoothing (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    xvs_in_if.sink                       i_in,
    xvs_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [xvs_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    xvs_pkg::t_cfg r_cfg;
    xvs_pkg::t_job front_job, queue_job;
    logic          push, pop, full, empty;
    logic [2:0]    reg_idx;

    // register file
    assign pready  = 1'b1;
    assign reg_idx = paddr[xvs_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dims       <= 2'd3;
            r_cfg.coef_water <= '0;
            r_cfg.coef_soil  <= '0;
            r_cfg.coef_air   <= '0;
            r_cfg.thresh     <= 16'd1;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                xvs_pkg::REG_DIMS:   r_cfg.dims       <= pwdata[1:0];
                xvs_pkg::REG_WATER:  r_cfg.coef_water <= pwdata[15:0];
                xvs_pkg::REG_SOIL:   r_cfg.coef_soil  <= pwdata[15:0];
                xvs_pkg::REG_AIR:    r_cfg.coef_air   <= pwdata[15:0];
                xvs_pkg::REG_THRESH: r_cfg.thresh     <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            xvs_pkg::REG_DIMS:   prdata = 32'(r_cfg.dims);
            xvs_pkg::REG_WATER:  prdata = 32'(r_cfg.coef_water);
            xvs_pkg::REG_SOIL:   prdata = 32'(r_cfg.coef_soil);
            xvs_pkg::REG_AIR:    prdata = 32'(r_cfg.coef_air);
            xvs_pkg::REG_THRESH: prdata = 32'(r_cfg.thresh);
            default:             prdata = '0;
        endcase
    end

    // front: accept, classify, pair weight
    xvs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .o_job   (front_job),
        .o_push  (push),
        .i_full  (full)
    );

    // decoupling queue
    xvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (queue_job),
        .o_empty (empty)
    );

    // back: accumulate, normalize, emit
    xvs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_job   (queue_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
